// ===== rtl/core/imhq_pkg.sv =====
//------------------------------------------------------------------------------
// imhq_pkg
// shared types and codes for the indexed min-heap queue
//------------------------------------------------------------------------------
package imhq_pkg;

    localparam int unsigned VertexWidth = 10;
    localparam int unsigned KeyWidth    = 32;
    localparam int unsigned StatusWidth = 3;

    typedef enum logic [1:0] {
        KIND_INSERT   = 2'd0,
        KIND_DECREASE = 2'd1,
        KIND_DELETE   = 2'd2,
        KIND_NONE     = 2'd3
    } t_kind;

    typedef enum logic [StatusWidth-1:0] {
        ST_OK      = 3'd0,
        ST_EMPTY   = 3'd1,
        ST_PRESENT = 3'd2,
        ST_ABSENT  = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    // compare unit request and answer
    typedef struct packed {
        logic [KeyWidth-1:0] a;
        logic [KeyWidth-1:0] b;
    } t_cmp_req;

    typedef struct packed {
        logic a_gt_b;
        logic b_lt_a;
    } t_cmp_rsp;

endpackage

// ===== rtl/core/indexed_min_heap_queue_unit.sv =====
//------------------------------------------------------------------------------
// indexed_min_heap_queue_unit
// indexed binary min-heap over vertex ids, sifted by a small sequencer
//------------------------------------------------------------------------------
// channel   dir  tdata bits (low up)                tuser
// s_axis    in   kind[1:0] vertex[11:2] key[43:12]   -
// m_axis    out  removed[9:0] status[12:10] min[22:13] count[33:23]
//                is_empty[34] was_present[35]
// one read and one write port per store and the single comparator set the
// pace: a level of sift-up steps through read, key read, compare and write,
// a level of sift-down through left, right and key reads, select, compare
// and write; no new item is accepted until the last result is registered;
// insert and decrease key climb level by level, delete minimum descends
// after reset a clearing pass over all MAX_VERTICES entries fills position
// and key stores; no item is accepted meanwhile
// the result waits in its own output register; a stalled output holds the
// sequencer at its last step
//------------------------------------------------------------------------------
module indexed_min_heap_queue_unit #(
    parameter int unsigned MAX_VERTICES = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // kind, vertex, key
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // removed, status, min, count, empty, present
);

    localparam int unsigned AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int unsigned SW = $clog2(MAX_VERTICES + 1);
    localparam int unsigned VW = imhq_pkg::VertexWidth;
    localparam int unsigned KW = imhq_pkg::KeyWidth;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_LOOK, S_DISPATCH,
        S_INS_W, S_DEC_W,
        S_UP_RD, S_UP_RK, S_UP_CMP, S_UP_WR,
        S_DEL_RD, S_DEL_WR, S_DEL_KEY,
        S_DN_RD1, S_DN_RD2, S_DN_RD3, S_DN_SEL, S_DN_CMP, S_DN_WR,
        S_ROOT, S_OUT
    } t_state;

    // memories
    logic [VW-1:0] heap_mem [MAX_VERTICES];
    logic [SW-1:0] pos_mem  [MAX_VERTICES];
    logic [KW-1:0] key_mem  [MAX_VERTICES];

    t_state        r_state;
    logic [AW-1:0] r_clr;
    logic [1:0]    r_kind;
    logic [VW-1:0] r_vtx;
    logic [KW-1:0] r_key;
    logic [SW-1:0] r_cnt;
    logic [SW-1:0] r_s;     // current slot of moving vertex
    logic [SW-1:0] r_c;     // other slot
    logic [VW-1:0] r_me;
    logic [VW-1:0] r_oth;
    logic [VW-1:0] r_oth2;
    logic [KW-1:0] r_kme;
    logic [KW-1:0] r_koth;
    logic          r_two;
    logic          r_pres;
    logic [SW-1:0] r_pos;
    logic [VW-1:0] r_removed;
    imhq_pkg::t_status r_status;
    logic          r_ovalid;
    logic [39:0]   r_odata;

    // single-port style read registers
    logic [VW-1:0] r_hrd;
    logic [SW-1:0] r_prd;
    logic [KW-1:0] r_krd;

    logic          h_we, p_we, k_we;
    logic [AW-1:0] h_wa, p_wa, k_wa, h_ra, p_ra, k_ra;
    logic [VW-1:0] h_wd;
    logic [SW-1:0] p_wd;
    logic [KW-1:0] k_wd;

    imhq_pkg::t_cmp_req cmp_req;
    imhq_pkg::t_cmp_rsp cmp_rsp;

    imhq_cmp u_cmp (.i_req(cmp_req), .o_rsp(cmp_rsp));

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s);
        logic [SW-1:0] t;
        t = s - SW'(1);
        return t[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] vaddr(input logic [VW-1:0] v);
        logic [31:0] t;
        t = 32'(v);
        return t[AW-1:0];
    endfunction

    wire [1:0]    in_kind  = s_axis_tdata[1:0];
    wire [VW-1:0] in_vtx   = s_axis_tdata[11:2];
    wire [KW-1:0] in_key   = s_axis_tdata[43:12];
    wire          vtx_inr  = ({22'd0, r_vtx} < 32'(MAX_VERTICES));
    wire          vtx_pres = vtx_inr && (r_prd != '0);
    wire [SW:0]   dn_left  = {r_s, 1'b0};
    wire [SW:0]   dn_right = {r_s, 1'b1};
    wire [SW:0]   cnt_x    = {1'b0, r_cnt};
    wire          out_free = !r_ovalid || m_axis_tready;

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

    // comparator operands: heap order tests use strict compares
    always_comb begin
        unique case (r_state)
            S_DISPATCH: begin cmp_req.a = r_krd;  cmp_req.b = r_key;  end
            S_UP_CMP:   begin cmp_req.a = r_krd;  cmp_req.b = r_kme;  end
            S_DN_SEL:   begin cmp_req.a = r_koth; cmp_req.b = r_krd;  end
            default:    begin cmp_req.a = r_kme;  cmp_req.b = r_koth; end
        endcase
    end

    // memory port control
    always_comb begin
        h_we = 1'b0; p_we = 1'b0; k_we = 1'b0;
        h_wa = '0; p_wa = '0; k_wa = '0;
        h_wd = '0; p_wd = '0; k_wd = '0;
        h_ra = '0; p_ra = vaddr(r_vtx); k_ra = vaddr(r_vtx);
        unique case (r_state)
            S_CLEAR: begin
                p_we = 1'b1; k_we = 1'b1;
                p_wa = r_clr; k_wa = r_clr;
                p_wd = '0; k_wd = '1;
            end
            S_INS_W: begin
                h_we = 1'b1; h_wa = slot_addr(r_cnt); h_wd = r_vtx;
                p_we = 1'b1; p_wa = vaddr(r_vtx); p_wd = r_cnt;
                k_we = 1'b1; k_wa = vaddr(r_vtx); k_wd = r_key;
            end
            S_DEC_W: begin
                k_we = 1'b1; k_wa = vaddr(r_vtx); k_wd = r_key;
            end
            S_UP_RD:   h_ra = slot_addr(r_s >> 1);
            S_UP_RK:   k_ra = vaddr(r_hrd);
            S_UP_CMP: begin
                h_we = cmp_rsp.a_gt_b; h_wa = slot_addr(r_s); h_wd = r_oth;
                p_we = cmp_rsp.a_gt_b; p_wa = vaddr(r_oth); p_wd = r_s;
            end
            S_UP_WR: begin
                h_we = 1'b1; h_wa = slot_addr(r_c); h_wd = r_me;
                p_we = 1'b1; p_wa = vaddr(r_me); p_wd = r_c;
            end
            S_DEL_RD: begin
                h_ra = slot_addr(r_cnt);
                p_we = 1'b1; p_wa = vaddr(r_removed); p_wd = '0;
            end
            S_DEL_WR: begin
                h_we = 1'b1; h_wa = '0; h_wd = r_hrd;
                // last vertex moves to the root unless it was the root
                p_we = (r_cnt != SW'(1)); p_wa = vaddr(r_hrd); p_wd = SW'(1);
                k_ra = vaddr(r_hrd);
            end
            S_DN_RD1:  h_ra = slot_addr(dn_left[SW-1:0]);
            S_DN_RD2: begin
                h_ra = slot_addr(r_c + SW'(1));
                k_ra = vaddr(r_hrd);
            end
            S_DN_RD3:  k_ra = vaddr(r_hrd);
            S_DN_CMP: begin
                h_we = cmp_rsp.a_gt_b; h_wa = slot_addr(r_s); h_wd = r_oth;
                p_we = cmp_rsp.a_gt_b; p_wa = vaddr(r_oth); p_wd = r_s;
            end
            S_DN_WR: begin
                h_we = 1'b1; h_wa = slot_addr(r_c); h_wd = r_me;
                p_we = 1'b1; p_wa = vaddr(r_me); p_wd = r_c;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (h_we) heap_mem[h_wa] <= h_wd;
        if (p_we) pos_mem[p_wa]  <= p_wd;
        if (k_we) key_mem[k_wa]  <= k_wd;
        r_hrd <= heap_mem[h_ra];
        r_prd <= pos_mem[p_ra];
        r_krd <= key_mem[k_ra];
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_OUT && out_free) r_ovalid <= 1'b1;
            else if (m_axis_tready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + AW'(1);
                    if (r_clr == AW'(MAX_VERTICES - 1)) r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_kind    <= in_kind;
                        r_vtx     <= in_vtx;
                        r_key     <= in_key;
                        r_removed <= '0;
                        r_status  <= imhq_pkg::ST_OK;
                        r_state   <= S_LOOK;
                    end
                end
                S_LOOK: r_state <= S_DISPATCH;  // reads of pos, key and root settle
                S_DISPATCH: begin
                    r_pres <= vtx_pres;
                    r_pos  <= r_prd;
                    unique case (imhq_pkg::t_kind'(r_kind))
                        imhq_pkg::KIND_INSERT: begin
                            if (vtx_pres) begin
                                r_status <= imhq_pkg::ST_PRESENT;
                                r_state  <= S_ROOT;
                            end else if (!vtx_inr || r_cnt == SW'(MAX_VERTICES)) begin
                                r_status <= imhq_pkg::ST_FULL;
                                r_state  <= S_ROOT;
                            end else begin
                                r_cnt   <= r_cnt + SW'(1);
                                r_state <= S_INS_W;
                            end
                        end
                        imhq_pkg::KIND_DECREASE: begin
                            if (!vtx_pres) begin
                                r_status <= imhq_pkg::ST_ABSENT;
                                r_state  <= S_ROOT;
                            end else begin
                                r_state <= cmp_rsp.a_gt_b ? S_DEC_W : S_ROOT;
                            end
                        end
                        imhq_pkg::KIND_DELETE: begin
                            if (r_cnt == '0) begin
                                r_status <= imhq_pkg::ST_EMPTY;
                                r_state  <= S_ROOT;
                            end else begin
                                r_removed <= r_hrd;
                                r_state   <= S_DEL_RD;
                            end
                        end
                        default: r_state <= S_ROOT;
                    endcase
                end
                S_INS_W: begin
                    r_s <= r_cnt; r_me <= r_vtx; r_kme <= r_key;
                    r_state <= S_UP_RD;
                end
                S_DEC_W: begin
                    r_s <= r_pos; r_me <= r_vtx; r_kme <= r_key;
                    r_state <= S_UP_RD;
                end
                S_UP_RD: r_state <= (r_s > SW'(1)) ? S_UP_RK : S_ROOT;
                S_UP_RK: begin
                    r_oth   <= r_hrd;
                    r_c     <= r_s >> 1;
                    r_state <= S_UP_CMP;
                end
                S_UP_CMP: r_state <= cmp_rsp.a_gt_b ? S_UP_WR : S_ROOT;
                S_UP_WR: begin
                    r_s     <= r_c;
                    r_state <= S_UP_RD;
                end
                S_DEL_RD: r_state <= S_DEL_WR;
                S_DEL_WR: begin
                    r_me    <= r_hrd;
                    r_s     <= SW'(1);
                    r_cnt   <= r_cnt - SW'(1);
                    r_state <= S_DEL_KEY;
                end
                S_DEL_KEY: begin
                    r_kme   <= r_krd;
                    r_state <= S_DN_RD1;
                end
                S_DN_RD1: begin
                    if (dn_left > cnt_x) begin
                        r_state <= S_ROOT;
                    end else begin
                        r_c     <= dn_left[SW-1:0];
                        r_two   <= (dn_right <= cnt_x);
                        r_state <= S_DN_RD2;
                    end
                end
                S_DN_RD2: begin
                    r_oth   <= r_hrd;
                    r_state <= S_DN_RD3;
                end
                S_DN_RD3: begin
                    r_koth  <= r_krd;
                    r_oth2  <= r_hrd;
                    r_state <= S_DN_SEL;
                end
                S_DN_SEL: begin
                    if (r_two && cmp_rsp.b_lt_a) begin
                        r_oth  <= r_oth2;
                        r_koth <= r_krd;
                        r_c    <= r_c + SW'(1);
                    end
                    r_state <= S_DN_CMP;
                end
                S_DN_CMP: r_state <= cmp_rsp.a_gt_b ? S_DN_WR : S_ROOT;
                S_DN_WR: begin
                    r_s     <= r_c;
                    r_state <= S_DN_RD1;
                end
                S_ROOT: r_state <= S_OUT;
                S_OUT: begin
                    if (out_free) begin
                        r_odata <= {4'd0, r_pres, (r_cnt == '0), 11'(r_cnt),
                                    ((r_cnt != '0) ? r_hrd : VW'(0)),
                                    r_status, r_removed};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= SW'(MAX_VERTICES)) else $error("count overflow");
    a_out_raise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> r_ovalid) else $error("result not raised");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

// ===== rtl/core/imhq_cmp.sv =====
//------------------------------------------------------------------------------
// imhq_cmp
// shared key comparator used by dispatch and by every sift compare
//------------------------------------------------------------------------------
module imhq_cmp (
    input  imhq_pkg::t_cmp_req i_req,
    output imhq_pkg::t_cmp_rsp o_rsp
);

    assign o_rsp.a_gt_b = i_req.a > i_req.b;
    assign o_rsp.b_lt_a = i_req.b < i_req.a;

endmodule
